[hw/rtl/tkf_pkg.sv]
// Package for the tilt Kalman filter core: default sizes, operand codes and
// the step program that drives the shared multiplier, divider and adder.
// No dependencies.
package tkf_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int IO_FRAC        = 16;
  localparam int CFG_W          = 24;
  localparam int CFG_IDX_W      = 2;
  localparam int STEP_W         = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_Q_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_BIAS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_R_MEAS  = 2'd2;

  localparam logic [CFG_W-1:0] RST_Q_ANGLE = 24'd66;
  localparam logic [CFG_W-1:0] RST_Q_BIAS  = 24'd197;
  localparam logic [CFG_W-1:0] RST_R_MEAS  = 24'd1966;

  localparam logic [STEP_W-1:0] LAST_STEP = 5'd19;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_DIV
  } op_kind_e;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_Z, SRC_G, SRC_DT, SRC_QA, SRC_QB, SRC_R,
    SRC_A, SRC_B, SRC_P0, SRC_P1, SRC_P2, SRC_P3,
    SRC_RATE, SRC_D, SRC_T, SRC_Y, SRC_S, SRC_K0, SRC_K1
  } src_e;

  typedef struct packed {
    op_kind_e kind;
    src_e     ma;
    src_e     mb;
    src_e     c;
    logic     sub;
    src_e     dst;
  } uop_t;

  function automatic uop_t mk(input op_kind_e k, input src_e a, input src_e b,
                              input src_e c, input logic s, input src_e d);
    uop_t u;
    u.kind = k;
    u.ma   = a;
    u.mb   = b;
    u.c    = c;
    u.sub  = s;
    u.dst  = d;
    return u;
  endfunction

  // An add step gives dst = c -/+ mb; a multiply or divide step gives
  // dst = c -/+ (ma op mb).
  function automatic uop_t decode_step(input logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      5'd0:    u = mk(OP_ADD, SRC_ZERO, SRC_B,    SRC_G,    1'b1, SRC_RATE);
      5'd1:    u = mk(OP_MUL, SRC_DT,   SRC_RATE, SRC_A,    1'b0, SRC_A);
      5'd2:    u = mk(OP_MUL, SRC_DT,   SRC_P3,   SRC_ZERO, 1'b0, SRC_D);
      5'd3:    u = mk(OP_ADD, SRC_ZERO, SRC_P2,   SRC_D,    1'b1, SRC_T);
      5'd4:    u = mk(OP_ADD, SRC_ZERO, SRC_P1,   SRC_T,    1'b1, SRC_T);
      5'd5:    u = mk(OP_ADD, SRC_ZERO, SRC_QA,   SRC_T,    1'b0, SRC_T);
      5'd6:    u = mk(OP_MUL, SRC_DT,   SRC_T,    SRC_P0,   1'b0, SRC_P0);
      5'd7:    u = mk(OP_ADD, SRC_ZERO, SRC_D,    SRC_P1,   1'b1, SRC_P1);
      5'd8:    u = mk(OP_ADD, SRC_ZERO, SRC_D,    SRC_P2,   1'b1, SRC_P2);
      5'd9:    u = mk(OP_MUL, SRC_QB,   SRC_DT,   SRC_P3,   1'b0, SRC_P3);
      5'd10:   u = mk(OP_ADD, SRC_ZERO, SRC_A,    SRC_Z,    1'b1, SRC_Y);
      5'd11:   u = mk(OP_ADD, SRC_ZERO, SRC_R,    SRC_P0,   1'b0, SRC_S);
      5'd12:   u = mk(OP_DIV, SRC_P0,   SRC_S,    SRC_ZERO, 1'b0, SRC_K0);
      5'd13:   u = mk(OP_DIV, SRC_P2,   SRC_S,    SRC_ZERO, 1'b0, SRC_K1);
      5'd14:   u = mk(OP_MUL, SRC_K0,   SRC_Y,    SRC_A,    1'b0, SRC_A);
      5'd15:   u = mk(OP_MUL, SRC_K1,   SRC_Y,    SRC_B,    1'b0, SRC_B);
      5'd16:   u = mk(OP_MUL, SRC_K1,   SRC_P0,   SRC_P2,   1'b1, SRC_P2);
      5'd17:   u = mk(OP_MUL, SRC_K1,   SRC_P1,   SRC_P3,   1'b1, SRC_P3);
      5'd18:   u = mk(OP_MUL, SRC_K0,   SRC_P0,   SRC_P0,   1'b1, SRC_P0);
      5'd19:   u = mk(OP_MUL, SRC_K0,   SRC_P1,   SRC_P1,   1'b1, SRC_P1);
      default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b0, SRC_ZERO);
    endcase
    return u;
  endfunction

endpackage

[hw/rtl/tilt_kalman_filter_core.sv]
// Top level of the tilt Kalman filter: a twenty-step program run on one
// shared saturating adder, one W x 16 multiplier and a restoring divider.
// Depends on tkf_pkg.
//
// Channel | Direction | Handshake              | Word
// input   | in        | in_valid_i/in_ready_o  | measured_angle, gyro_rate, time_step
// output  | out       | out_valid_o/out_ready_i| filtered_angle, unbiased_rate, bias_estimate
// config  | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Each word runs through all twenty steps from its acceptance to its output
// word, and input is ready again only once that word has left the output state,
// so a new word cannot start before the last one is through; the two divisions
// in the restoring divider, one quotient bit per cycle, take most of the time.
// Reset clears the estimates and the covariance and loads the default noise
// values. Input is taken only when the sequencer is idle; a finished word
// waits in the output register, and the sequencer holds in its output state
// while an earlier word is still unread.
module tilt_kalman_filter_core
  import tkf_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [31:0]    measured_angle_i,
  input  logic signed [31:0]    gyro_rate_i,
  input  logic        [15:0]    time_step_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    filtered_angle_o,
  output logic signed [31:0]    unbiased_rate_o,
  output logic signed [31:0]    bias_estimate_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int W     = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int IW    = (W > 40 ? W : 40) + 10;
  localparam int UPS   = (F >= IO_FRAC) ? F - IO_FRAC : 0;
  localparam int DNS   = (F >= IO_FRAC) ? 0 : IO_FRAC - F;
  localparam int NCH   = (W + 15) / 16;
  localparam int UBW   = NCH * 16;
  localparam int PW    = 2 * W;
  localparam int NDIV  = W + F;
  localparam int MCW   = $clog2(NCH + 1);
  localparam int DCW   = $clog2(NDIV + 1);

  localparam logic signed [IW-1:0] MAXW = $signed({{(IW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [IW-1:0] MINW = -MAXW - IW'(1);
  localparam logic signed [IW-1:0] MAX32 = $signed({{(IW-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [IW-1:0] MIN32 = -MAX32 - IW'(1);
  localparam logic signed [IW-1:0] HALF_IN =
    (DNS > 0) ? (IW'(1) << (DNS > 0 ? DNS - 1 : 0)) : '0;
  localparam logic signed [IW-1:0] HALF_OUT =
    (UPS > 0) ? (IW'(1) << (UPS > 0 ? UPS - 1 : 0)) : '0;
  localparam logic [PW:0]  HALF_P = (PW + 1)'(1) << (F - 1);
  localparam logic [W+1:0] LIM    = (W + 2)'(1) << (W - 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_MFIN  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DFIN  = 3'd5;
  localparam logic [2:0] ST_WB    = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  function automatic logic signed [W-1:0] sat_w(input logic signed [IW-1:0] v);
    if (v > MAXW) return WMAX;
    if (v < MINW) return WMIN;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] from_io(input logic signed [32:0] v);
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] t;
    x = IW'(v);
    if (F >= IO_FRAC) t = x <<< UPS;
    else t = (x + HALF_IN) >>> DNS;
    return sat_w(t);
  endfunction

  function automatic logic signed [31:0] to_io(input logic signed [W-1:0] v);
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] t;
    x = IW'(v);
    if (F >= IO_FRAC) t = (x + HALF_OUT) >>> UPS;
    else t = x <<< DNS;
    if (t > MAX32) return 32'sh7fffffff;
    if (t < MIN32) return 32'sh80000000;
    return t[31:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [CFG_W-1:0]  cfg_qa_q, cfg_qb_q, cfg_r_q;

  logic signed [W-1:0] z_q, g_q, dt_q, qa_q, qb_q, r_q;
  logic signed [W-1:0] a_q, b_q, p0_q, p1_q, p2_q, p3_q;
  logic signed [W-1:0] rate_q, d_q, t_q, y_q, s_q, k0_q, k1_q;
  logic signed [W-1:0] x_q;

  logic [W-1:0]     ua_q;
  logic [UBW-1:0]   ub_q;
  logic [PW-1:0]    acc_q;
  logic             neg_q;
  logic [MCW-1:0]   mcnt_q;
  logic [NDIV-1:0]  num_q;
  logic [W-1:0]     den_q;
  logic [W-1:0]     rem_q;
  logic [W:0]       quo_q;
  logic             over_q;
  logic [DCW-1:0]   dcnt_q;

  logic                out_valid_q;
  logic signed [31:0]  fa_q, ur_q, be_q;

  uop_t                uop;
  logic signed [W-1:0] opa, opb, opc;
  logic signed [W:0]   sum;
  logic signed [W-1:0] wb_val;
  logic                in_acc;
  logic                out_load;

  function automatic logic signed [W-1:0] pick(
    input src_e s,
    input logic signed [W-1:0] z, g, dt, qa, qb, r, a, b,
    input logic signed [W-1:0] p0, p1, p2, p3, rt, d, t, y, sv, k0, k1
  );
    case (s)
      SRC_Z:    return z;
      SRC_G:    return g;
      SRC_DT:   return dt;
      SRC_QA:   return qa;
      SRC_QB:   return qb;
      SRC_R:    return r;
      SRC_A:    return a;
      SRC_B:    return b;
      SRC_P0:   return p0;
      SRC_P1:   return p1;
      SRC_P2:   return p2;
      SRC_P3:   return p3;
      SRC_RATE: return rt;
      SRC_D:    return d;
      SRC_T:    return t;
      SRC_Y:    return y;
      SRC_S:    return sv;
      SRC_K0:   return k0;
      SRC_K1:   return k1;
      default:  return '0;
    endcase
  endfunction

  assign uop = decode_step(step_q);
  assign opa = pick(uop.ma, z_q, g_q, dt_q, qa_q, qb_q, r_q, a_q, b_q, p0_q, p1_q,
                    p2_q, p3_q, rate_q, d_q, t_q, y_q, s_q, k0_q, k1_q);
  assign opb = pick(uop.mb, z_q, g_q, dt_q, qa_q, qb_q, r_q, a_q, b_q, p0_q, p1_q,
                    p2_q, p3_q, rate_q, d_q, t_q, y_q, s_q, k0_q, k1_q);
  assign opc = pick(uop.c, z_q, g_q, dt_q, qa_q, qb_q, r_q, a_q, b_q, p0_q, p1_q,
                    p2_q, p3_q, rate_q, d_q, t_q, y_q, s_q, k0_q, k1_q);

  assign sum = uop.sub ? ((W + 1)'(opc) - (W + 1)'(x_q)) : ((W + 1)'(opc) + (W + 1)'(x_q));
  assign wb_val = (sum[W] != sum[W-1]) ? (sum[W] ? WMIN : WMAX) : sum[W-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Multiplier step: one 16-bit slice of the second magnitude per cycle.
  logic [PW-1:0] acc_next;
  assign acc_next = (acc_q << 16) + PW'(ua_q * ub_q[UBW-1 -: 16]);

  logic [PW:0]  mrnd;
  logic [PW:0]  mq;
  logic [PW:0]  mlim;
  logic signed [W-1:0] mres;
  assign mrnd = {1'b0, acc_q} + HALF_P;
  assign mq   = mrnd >> F;
  assign mlim = neg_q ? (PW + 1)'(LIM) : (PW + 1)'(LIM) - (PW + 1)'(1);
  assign mres = (mq > mlim) ? (neg_q ? WMIN : WMAX)
              : (neg_q ? W'(-mq[W-1:0]) : mq[W-1:0]);

  // Divider step: restoring, one quotient bit per cycle.
  logic [W:0]   rem2;
  logic         ge;
  logic [W:0]   rem_n;
  logic [W+1:0] quo2;
  logic [W+1:0] dlim;
  logic signed [W-1:0] dres;
  assign rem2  = {rem_q, num_q[NDIV-1]};
  assign ge    = rem2 >= {1'b0, den_q};
  assign rem_n = ge ? rem2 - {1'b0, den_q} : rem2;
  assign quo2  = {quo_q, ge};
  assign dlim  = neg_q ? LIM : LIM - (W + 2)'(1);
  assign dres  = (over_q || ((W + 2)'(quo_q) > dlim)) ? (neg_q ? WMIN : WMAX)
               : (neg_q ? W'(-quo_q[W-1:0]) : quo_q[W-1:0]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_FETCH;
      ST_FETCH: begin
        unique case (uop.kind)
          OP_MUL:  state_d = ST_MUL;
          OP_DIV:  state_d = (opb == '0) ? ST_WB : ST_DIV;
          default: state_d = ST_WB;
        endcase
      end
      ST_MUL:   if (mcnt_q == MCW'(1)) state_d = ST_MFIN;
      ST_MFIN:  state_d = ST_WB;
      ST_DIV:   if (dcnt_q == DCW'(1)) state_d = ST_DFIN;
      ST_DFIN:  state_d = ST_WB;
      ST_WB:    state_d = (step_q == LAST_STEP) ? ST_OUT : ST_FETCH;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cfg_qa_q    <= RST_Q_ANGLE;
      cfg_qb_q    <= RST_Q_BIAS;
      cfg_r_q     <= RST_R_MEAS;
      out_valid_q <= 1'b0;
      a_q  <= '0;
      b_q  <= '0;
      p0_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_Q_ANGLE: cfg_qa_q <= cfg_data_i;
          CFG_Q_BIAS:  cfg_qb_q <= cfg_data_i;
          CFG_R_MEAS:  cfg_r_q  <= cfg_data_i;
          default:     ;
        endcase
      end
      if (in_acc) step_q <= '0;
      else if (state_q == ST_WB && step_q != LAST_STEP) step_q <= step_q + STEP_W'(1);
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_WB) begin
        case (uop.dst)
          SRC_A:  a_q  <= wb_val;
          SRC_B:  b_q  <= wb_val;
          SRC_P0: p0_q <= wb_val;
          SRC_P1: p1_q <= wb_val;
          SRC_P2: p2_q <= wb_val;
          SRC_P3: p3_q <= wb_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      z_q  <= from_io(33'(measured_angle_i));
      g_q  <= from_io(33'(gyro_rate_i));
      dt_q <= from_io($signed({17'b0, time_step_i}));
      qa_q <= from_io($signed({9'b0, cfg_qa_q}));
      qb_q <= from_io($signed({9'b0, cfg_qb_q}));
      r_q  <= from_io($signed({9'b0, cfg_r_q}));
    end
    unique case (state_q)
      ST_FETCH: begin
        neg_q <= opa[W-1] ^ opb[W-1];
        x_q   <= (uop.kind == OP_ADD) ? opb : '0;
        ua_q  <= mag(opa);
        ub_q  <= UBW'(mag(opb));
        acc_q <= '0;
        mcnt_q <= MCW'(NCH);
        num_q <= {mag(opa), {F{1'b0}}};
        den_q <= mag(opb);
        rem_q <= '0;
        quo_q <= '0;
        over_q <= 1'b0;
        dcnt_q <= DCW'(NDIV);
      end
      ST_MUL: begin
        acc_q  <= acc_next;
        ub_q   <= ub_q << 16;
        mcnt_q <= mcnt_q - MCW'(1);
      end
      ST_MFIN: x_q <= mres;
      ST_DIV: begin
        rem_q  <= rem_n[W-1:0];
        num_q  <= num_q << 1;
        quo_q  <= quo2[W:0];
        if (quo2 > LIM) over_q <= 1'b1;
        dcnt_q <= dcnt_q - DCW'(1);
      end
      ST_DFIN: x_q <= dres;
      ST_WB: begin
        case (uop.dst)
          SRC_RATE: rate_q <= wb_val;
          SRC_D:    d_q    <= wb_val;
          SRC_T:    t_q    <= wb_val;
          SRC_Y:    y_q    <= wb_val;
          SRC_S:    s_q    <= wb_val;
          SRC_K0:   k0_q   <= wb_val;
          SRC_K1:   k1_q   <= wb_val;
          default:  ;
        endcase
      end
      default: ;
    endcase
    if (out_load) begin
      fa_q <= to_io(a_q);
      ur_q <= to_io(rate_q);
      be_q <= to_io(b_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_angle_o = fa_q;
  assign unbiased_rate_o  = ur_q;
  assign bias_estimate_o  = be_q;

endmodule
